// ----- rtl/cbt_pkg.sv -----
// Shared types and constants for the cubic B-spline tessellator.
// No dependencies; imported by the controller, datapath and top level.
package cbt_pkg;

   // one control point in, one curve point out
   typedef struct packed {
      logic signed [15:0] px;
      logic signed [15:0] py;
      logic signed [15:0] pz;
      logic               restart;
      logic               close_curve;
   } req_data_type;

   typedef struct packed {
      logic signed [15:0] qx;
      logic signed [15:0] qy;
      logic signed [15:0] qz;
      logic               last;
   } rsp_data_type;

   // Bezier control point selected by a conversion step
   localparam logic [1:0] CONV_START = 2'd0;
   localparam logic [1:0] CONV_C1    = 2'd1;
   localparam logic [1:0] CONV_C2    = 2'd2;
   localparam logic [1:0] CONV_END   = 2'd3;

   localparam logic [16:0] T_ONE       = 17'd65536;
   localparam logic [16:0] T_INC_RESET = 17'd6554;

   // divide-by-3 by reciprocal: bias to non-negative, multiply, shift by 20
   localparam logic signed [19:0] CONV_BIAS = 20'sd393216;
   localparam logic [18:0]        RECIP3    = 19'd349526;
   localparam logic [17:0]        Q_BIAS    = 18'd131072;

   localparam logic [1:0] SEEN_FULL = 2'd3;

   typedef struct packed {
      logic       take_point;
      logic       win_push_req;
      logic       win_clear;
      logic       win_push_np;
      logic       conv_issue;
      logic [1:0] conv_idx;
      logic       t_clear;
      logic       t_step;
      logic       issue;
      logic       issue_close;
      logic       issue_last;
   } ctl_cmd_type;

   typedef struct packed {
      logic adv;
      logic next_over;
   } dp_status_type;

endpackage

// ----- rtl/cubic_bspline_tessellator.sv -----
// Top level of the cubic B-spline tessellator.
// Instantiates cbt_ctrl and cbt_datapath; types come from cbt_pkg.
//
// Usage:
//   req_*  : one control point per transfer (valid/stall). restart empties the
//            window first; close_curve adds the segment end after the run.
//   rsp_*  : curve points (valid/stall); last marks the final point of an item.
//   csr_*  : write of t_increment (Q0.16 step), only while the block is idle.
// Sequence:
//   A point that arrives with restart or before the window is full only enters
//   the window and gives no result. With a full window an item is accepted, its
//   four Bezier points go through the per-axis divide-by-3 multipliers (one
//   Bezier point per cycle for all three axes), the last one is written back,
//   then one parameter per cycle while the output is not stalled is issued for
//   N = min(MAX_STEPS, 65536 / t_increment + 1) run points, N = MAX_STEPS for a
//   zero step, then the close point with close_curve. The de Casteljau pipeline
//   overlaps the next item's accept and conversion.
// Reset: window empty, t_increment = 6554, no results pending.
// Stall: a stalled result holds the whole evaluation pipeline; the controller
//   issues no new parameter until the output register drains.
module cubic_bspline_tessellator
   import cbt_pkg::*;
#(
   parameter int MAX_STEPS = 32
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_data_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_data_type rsp_data,
   input  logic         csr_wr_en,
   input  logic [16:0]  csr_wr_data
);

   ctl_cmd_type   cmd;
   dp_status_type status;

   // sequence: accept, convert, issue parameters
   cbt_ctrl #(
      .MAX_STEPS(MAX_STEPS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // window, conversion, evaluation pipeline and output register
   cbt_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

endmodule

// ----- rtl/cbt_datapath.sv -----
// Datapath: control-point window, B-spline to Bezier conversion and a
// three-stage de Casteljau pipeline with the output register. Uses cbt_pkg.
module cbt_datapath
   import cbt_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  ctl_cmd_type   cmd,
   output dp_status_type status,
   input  req_data_type  req_data,
   input  logic          csr_wr_en,
   input  logic [16:0]   csr_wr_data,
   input  logic          rsp_stall,
   output logic          rsp_valid,
   output rsp_data_type  rsp_data
);

   // round-to-nearest interpolation p + (q - p) * t, t in Q0.16
   function automatic logic signed [15:0] lerp(input logic signed [15:0] p,
                                               input logic signed [15:0] q,
                                               input logic [16:0]        t);
      logic signed [16:0] diff;
      logic signed [17:0] ts;
      logic signed [34:0] prod;
      logic signed [35:0] num;
      logic signed [19:0] rnd;
      logic signed [15:0] res;
      diff = $signed({q[15], q}) - $signed({p[15], p});
      ts   = $signed({1'b0, t});
      prod = 35'(diff) * 35'(ts);
      num  = $signed({prod[34], prod}) + $signed({{4{p[15]}}, p, 16'h8000});
      rnd  = num[35:16];
      if (rnd > 20'sd32767) begin
         res = 16'sh7fff;
      end else if (rnd < -20'sd32768) begin
         res = 16'sh8000;
      end else begin
         res = rnd[15:0];
      end
      return res;
   endfunction

   logic [16:0]        t_inc_ff;
   logic [16:0]        t_ff;
   logic [17:0]        t_sum;
   logic [16:0]        t_issue;

   logic signed [15:0] win_ff [9];
   logic signed [15:0] np_ff  [3];
   logic signed [15:0] bez_ff [3][4];

   logic [37:0]        prod_ff  [3];
   logic [37:0]        prod_in  [3];
   logic [1:0]         cidx_ff;
   logic               cvalid_ff;

   logic signed [15:0] l_ff [3][3];
   logic signed [15:0] l_in [3][3];
   logic signed [15:0] m_ff [3][2];
   logic signed [15:0] m_in [3][2];
   logic signed [15:0] q_in [3];
   logic [16:0]        t1_ff, t2_ff;
   logic               v1_ff, v2_ff, last1_ff, last2_ff;
   rsp_data_type       rsp_ff;
   logic               rsp_valid_ff;
   logic               adv;

   assign adv              = !rsp_valid_ff || !rsp_stall;
   assign t_sum            = {1'b0, t_ff} + {1'b0, t_inc_ff};
   assign t_issue          = cmd.issue_close ? T_ONE : t_ff;
   assign status.adv       = adv;
   assign status.next_over = t_sum > {1'b0, T_ONE};
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data         = rsp_ff;

   // conversion numerator per lane, then the reciprocal multiply
   always_comb begin
      logic signed [19:0] e0, e1, e2, e3, n, x, u;
      for (int j = 0; j < 3; j++) begin
         e0 = 20'(win_ff[j]);
         e1 = 20'(win_ff[3 + j]);
         e2 = 20'(win_ff[6 + j]);
         e3 = 20'(np_ff[j]);
         case (cmd.conv_idx)
            CONV_START: n = e0 + (e1 <<< 2) + e2;
            CONV_C1:    n = (e1 <<< 1) + e2;
            CONV_C2:    n = e1 + (e2 <<< 1);
            CONV_END:   n = e1 + (e2 <<< 2) + e3;
            default:    n = '0;
         endcase
         if (cmd.conv_idx == CONV_START || cmd.conv_idx == CONV_END) begin
            x = (n + 20'sd3) >>> 1;
         end else begin
            x = n + 20'sd1;
         end
         u = x + CONV_BIAS;
         prod_in[j] = 38'(u[18:0]) * 38'(RECIP3);
      end
   end

   // de Casteljau levels
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         for (int i = 0; i < 3; i++) begin
            l_in[j][i] = lerp(bez_ff[j][i], bez_ff[j][i + 1], t_issue);
         end
         for (int i = 0; i < 2; i++) begin
            m_in[j][i] = lerp(l_ff[j][i], l_ff[j][i + 1], t1_ff);
         end
         q_in[j] = lerp(m_ff[j][0], m_ff[j][1], t2_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t_inc_ff     <= T_INC_RESET;
         cvalid_ff    <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            t_inc_ff <= csr_wr_data;
         end
         cvalid_ff <= cmd.conv_issue;
         if (adv) begin
            v1_ff        <= cmd.issue;
            v2_ff        <= v1_ff;
            rsp_valid_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      logic [17:0] q18;
      if (cmd.t_clear) begin
         t_ff <= '0;
      end else if (cmd.t_step) begin
         t_ff <= t_sum[16:0];
      end

      if (cmd.take_point) begin
         np_ff[0] <= req_data.px;
         np_ff[1] <= req_data.py;
         np_ff[2] <= req_data.pz;
      end

      if (cmd.win_push_req) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= cmd.win_clear ? 16'sd0 : win_ff[i + 3];
         end
         win_ff[6] <= req_data.px;
         win_ff[7] <= req_data.py;
         win_ff[8] <= req_data.pz;
      end else if (cmd.win_push_np) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= win_ff[i + 3];
         end
         for (int j = 0; j < 3; j++) begin
            win_ff[6 + j] <= np_ff[j];
         end
      end

      if (cmd.conv_issue) begin
         cidx_ff <= cmd.conv_idx;
         for (int j = 0; j < 3; j++) begin
            prod_ff[j] <= prod_in[j];
         end
      end
      if (cvalid_ff) begin
         for (int j = 0; j < 3; j++) begin
            q18 = prod_ff[j][37:20] - Q_BIAS;
            bez_ff[j][cidx_ff] <= q18[15:0];
         end
      end

      if (adv) begin
         l_ff     <= l_in;
         t1_ff    <= t_issue;
         last1_ff <= cmd.issue_last;
         m_ff     <= m_in;
         t2_ff    <= t1_ff;
         last2_ff <= last1_ff;
         rsp_ff.qx   <= q_in[0];
         rsp_ff.qy   <= q_in[1];
         rsp_ff.qz   <= q_in[2];
         rsp_ff.last <= last2_ff;
      end
   end

endmodule

// ----- rtl/cbt_ctrl.sv -----
// Controller: accepts control points, sequences the Bezier conversion and issues
// one curve parameter per cycle while the datapath advances. Uses cbt_pkg.
module cbt_ctrl
   import cbt_pkg::*;
#(
   parameter int MAX_STEPS = 32
)
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  req_data_type  req_data,
   output logic          req_stall,
   input  dp_status_type status,
   output ctl_cmd_type   cmd
);

   localparam int KW = $clog2(MAX_STEPS + 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CONV  = 3'd1;
   localparam logic [2:0] ST_WAIT  = 3'd2;
   localparam logic [2:0] ST_RUN   = 3'd3;
   localparam logic [2:0] ST_CLOSE = 3'd4;

   logic [2:0]    state_ff, state_in;
   logic [1:0]    seen_ff, seen_in;
   logic [1:0]    cidx_ff, cidx_in;
   logic [KW-1:0] k_ff, k_in;
   logic          close_ff, close_in;
   logic          end_run;

   assign req_stall = (state_ff != ST_IDLE);
   assign end_run   = (k_ff == KW'(MAX_STEPS - 1)) || status.next_over;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      seen_in  = seen_ff;
      cidx_in  = cidx_ff;
      k_in     = k_ff;
      close_in = close_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.take_point = 1'b1;
               if (req_data.restart || seen_ff != SEEN_FULL) begin
                  cmd.win_push_req = 1'b1;
                  cmd.win_clear    = req_data.restart;
                  seen_in          = req_data.restart ? 2'd1 : seen_ff + 2'd1;
               end else begin
                  state_in = ST_CONV;
                  cidx_in  = CONV_START;
                  close_in = req_data.close_curve;
               end
            end
         end
         ST_CONV: begin
            cmd.conv_issue = 1'b1;
            cmd.conv_idx   = cidx_ff;
            if (cidx_ff == CONV_END) begin
               cmd.win_push_np = 1'b1;
               state_in        = ST_WAIT;
            end else begin
               cidx_in = cidx_ff + 2'd1;
            end
         end
         ST_WAIT: begin
            // last Bezier point lands this cycle
            cmd.t_clear = 1'b1;
            k_in        = '0;
            state_in    = ST_RUN;
         end
         ST_RUN: begin
            if (status.adv) begin
               cmd.issue      = 1'b1;
               cmd.t_step     = 1'b1;
               cmd.issue_last = !close_ff && end_run;
               if (end_run) begin
                  state_in = close_ff ? ST_CLOSE : ST_IDLE;
               end else begin
                  k_in = k_ff + 1'b1;
               end
            end
         end
         ST_CLOSE: begin
            if (status.adv) begin
               cmd.issue       = 1'b1;
               cmd.issue_close = 1'b1;
               cmd.issue_last  = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         seen_ff  <= '0;
      end else begin
         state_ff <= state_in;
         seen_ff  <= seen_in;
      end
      cidx_ff  <= cidx_in;
      k_ff     <= k_in;
      close_ff <= close_in;
   end

   a_issue_on_adv: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> status.adv)
      else $error("issue while pipeline held");

   a_conv_needs_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CONV) |-> (seen_ff == SEEN_FULL))
      else $error("conversion without a full window");

   a_close_is_last: assert property (@(posedge clock) disable iff (reset)
      (cmd.issue && cmd.issue_close) |-> cmd.issue_last)
      else $error("close point not marked last");

   a_run_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (k_ff <= KW'(MAX_STEPS - 1)))
      else $error("step count beyond limit");

endmodule
